// ===== rtl/core/fbpsw_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpsw_pkg
// Shared types and constants of the four-body phase-space weight block.
// ----------------------------------------------------------------------------
package fbpsw_pkg;

    localparam int WEIGHT_WIDTH    = 32;
    localparam int WEIGHT_FRACTION = 16;
    localparam int NUM_FLAGS       = 3;
    localparam int PADDR_WIDTH     = 5;
    localparam int PDATA_WIDTH     = 32;

    typedef enum logic [2:0] {
        REG_PARENT_MASS = 3'd0,
        REG_MASS_ONE    = 3'd1,
        REG_MASS_TWO    = 3'd2,
        REG_MASS_THREE  = 3'd3,
        REG_MASS_FOUR   = 3'd4,
        REG_WEIGHT_NORM = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

// ===== rtl/core/fbpsw_breakup.sv =====
// ----------------------------------------------------------------------------
// fbpsw_breakup
// Pipelined two-body breakup momentum: floor(sqrt(lambda) / (2m)), saturating.
// ----------------------------------------------------------------------------
module fbpsw_breakup #(
    parameter int VALUE_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fbpsw_pkg::t_pipe_ctl   i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_mass,
    input  logic [VALUE_WIDTH-1:0] i_part_x,
    input  logic [VALUE_WIDTH-1:0] i_part_y,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_momentum,
    output logic                   o_clamp
);

    localparam int VW    = VALUE_WIDTH;
    localparam int A12W  = 2 * VW + 3;
    localparam int A34W  = 2 * VW + 1;
    localparam int SPLIT = VW + 2;
    localparam int LW    = A12W + A34W;
    localparam int RW    = LW / 2;

    // stage 1: factors of lambda
    logic [VW:0]   mass_ext;
    logic [VW:0]   n_sum;
    logic [VW-1:0] n_diff;
    logic          n_neg;
    logic [VW:0]   n_f1;
    logic [VW+1:0] n_f2;
    logic [VW-1:0] n_f3;
    logic [VW:0]   n_f4;

    logic          r1_valid;
    logic          r1_neg;
    logic [VW-1:0] r1_mass;
    logic [VW:0]   r1_f1;
    logic [VW+1:0] r1_f2;
    logic [VW-1:0] r1_f3;
    logic [VW:0]   r1_f4;

    assign mass_ext = {1'b0, i_mass};
    assign n_sum    = {1'b0, i_part_x} + {1'b0, i_part_y};
    assign n_diff   = (i_part_x > i_part_y) ? i_part_x - i_part_y : i_part_y - i_part_x;
    assign n_neg    = (n_diff < i_mass) && (mass_ext < n_sum);
    assign n_f1     = (mass_ext > n_sum) ? mass_ext - n_sum : n_sum - mass_ext;
    assign n_f2     = {1'b0, mass_ext} + {1'b0, n_sum};
    assign n_f3     = (i_mass > n_diff) ? i_mass - n_diff : n_diff - i_mass;
    assign n_f4     = {1'b0, i_mass} + {1'b0, n_diff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r1_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_neg  <= n_neg;
            r1_mass <= i_mass;
            r1_f1   <= n_f1;
            r1_f2   <= n_f2;
            r1_f3   <= n_f3;
            r1_f4   <= n_f4;
        end
    end

    // stage 2: pair products
    logic            r2_valid;
    logic            r2_neg;
    logic [VW-1:0]   r2_mass;
    logic [A12W-1:0] r2_a12;
    logic [A34W-1:0] r2_a34;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r2_neg  <= r1_neg;
            r2_mass <= r1_mass;
            r2_a12  <= A12W'(r1_f1) * A12W'(r1_f2);
            r2_a34  <= A34W'(r1_f3) * A34W'(r1_f4);
        end
    end

    // stage 3: partial products of the wide multiply
    logic [SPLIT-1:0]         a12_lo;
    logic [A12W-SPLIT-1:0]    a12_hi;
    logic [SPLIT-1:0]         a34_lo;
    logic [A34W-SPLIT-1:0]    a34_hi;

    logic                              r3_valid;
    logic                              r3_neg;
    logic [VW-1:0]                     r3_mass;
    logic [2*SPLIT-1:0]                r3_ll;
    logic [SPLIT+A34W-SPLIT-1:0]       r3_lh;
    logic [A12W-SPLIT+SPLIT-1:0]       r3_hl;
    logic [A12W-SPLIT+A34W-SPLIT-1:0]  r3_hh;

    assign a12_lo = r2_a12[SPLIT-1:0];
    assign a12_hi = r2_a12[A12W-1:SPLIT];
    assign a34_lo = r2_a34[SPLIT-1:0];
    assign a34_hi = r2_a34[A34W-1:SPLIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r3_neg  <= r2_neg;
            r3_mass <= r2_mass;
            r3_ll   <= (2*SPLIT)'(a12_lo) * (2*SPLIT)'(a34_lo);
            r3_lh   <= A34W'(a12_lo) * A34W'(a34_hi);
            r3_hl   <= A12W'(a12_hi) * A12W'(a34_lo);
            r3_hh   <= (A12W+A34W-2*SPLIT)'(a12_hi) * (A12W+A34W-2*SPLIT)'(a34_hi);
        end
    end

    // stage 4: lambda, cleared on a negative radicand
    logic [LW-1:0] n_lambda;
    logic          r4_valid;
    logic          r4_neg;
    logic [VW-1:0] r4_mass;
    logic [LW-1:0] r4_lambda;

    assign n_lambda = LW'(r3_ll) + (LW'(r3_lh) << SPLIT) + (LW'(r3_hl) << SPLIT)
                    + (LW'(r3_hh) << (2 * SPLIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r4_neg    <= r3_neg;
            r4_mass   <= r3_mass;
            r4_lambda <= r3_neg ? '0 : n_lambda;
        end
    end

    // integer square root, one root bit per stage
    logic [LW-1:0] r_sq_rem   [RW];
    logic [RW-1:0] r_sq_root  [RW];
    logic [VW-1:0] r_sq_mass  [RW];
    logic          r_sq_neg   [RW];
    logic          r_sq_valid [RW];

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int BIT = RW - 1 - k;
        logic [LW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [VW-1:0] mass_in;
        logic          neg_in;
        logic          valid_in;
        logic [LW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in   = r4_lambda;
            assign root_in  = '0;
            assign mass_in  = r4_mass;
            assign neg_in   = r4_neg;
            assign valid_in = r4_valid;
        end else begin : g_next
            assign rem_in   = r_sq_rem[k-1];
            assign root_in  = r_sq_root[k-1];
            assign mass_in  = r_sq_mass[k-1];
            assign neg_in   = r_sq_neg[k-1];
            assign valid_in = r_sq_valid[k-1];
        end

        assign trial = (LW'(root_in) << (BIT + 1)) | (LW'(1) << (2 * BIT));
        assign take  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_sq_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_sq_rem[k]  <= take ? rem_in - trial : rem_in;
                r_sq_root[k] <= take ? (root_in | (RW'(1) << BIT)) : root_in;
                r_sq_mass[k] <= mass_in;
                r_sq_neg[k]  <= neg_in;
            end
        end
    end

    // root / 2m, greedy from the top quotient bit so it saturates
    logic [RW-1:0] r_dv_rem   [VW];
    logic [VW-1:0] r_dv_quo   [VW];
    logic [VW-1:0] r_dv_mass  [VW];
    logic          r_dv_neg   [VW];
    logic          r_dv_valid [VW];

    for (genvar k = 0; k < VW; k++) begin : g_div
        localparam int BIT = VW - 1 - k;
        logic [RW-1:0] rem_in;
        logic [VW-1:0] quo_in;
        logic [VW-1:0] mass_in;
        logic          neg_in;
        logic          valid_in;
        logic [RW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in   = r_sq_root[RW-1];
            assign quo_in   = '0;
            assign mass_in  = r_sq_mass[RW-1];
            assign neg_in   = r_sq_neg[RW-1];
            assign valid_in = r_sq_valid[RW-1];
        end else begin : g_next
            assign rem_in   = r_dv_rem[k-1];
            assign quo_in   = r_dv_quo[k-1];
            assign mass_in  = r_dv_mass[k-1];
            assign neg_in   = r_dv_neg[k-1];
            assign valid_in = r_dv_valid[k-1];
        end

        assign trial = RW'({mass_in, 1'b0}) << BIT;
        assign take  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_dv_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_dv_rem[k]  <= take ? rem_in - trial : rem_in;
                r_dv_quo[k]  <= take ? (quo_in | (VW'(1) << BIT)) : quo_in;
                r_dv_mass[k] <= mass_in;
                r_dv_neg[k]  <= neg_in;
            end
        end
    end

    assign o_valid    = r_dv_valid[VW-1];
    assign o_momentum = r_dv_quo[VW-1];
    assign o_clamp    = r_dv_neg[VW-1];

endmodule

// ===== rtl/core/fbpsw_weight.sv =====
// ----------------------------------------------------------------------------
// fbpsw_weight
// Pipelined weight qa*qb*qp / (norm << (2F-16)), floor, saturating.
// ----------------------------------------------------------------------------
module fbpsw_weight #(
    parameter int VALUE_WIDTH   = 24,
    parameter int FRACTION_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  fbpsw_pkg::t_pipe_ctl                  i_ctl,
    input  logic [VALUE_WIDTH-1:0]                i_norm,
    input  logic [VALUE_WIDTH-1:0]                i_qa,
    input  logic [VALUE_WIDTH-1:0]                i_qb,
    input  logic [VALUE_WIDTH-1:0]                i_qp,
    input  logic [fbpsw_pkg::NUM_FLAGS-1:0]       i_flags,
    output logic                                  o_valid,
    output logic [VALUE_WIDTH-1:0]                o_qa,
    output logic [VALUE_WIDTH-1:0]                o_qb,
    output logic [VALUE_WIDTH-1:0]                o_qp,
    output logic [fbpsw_pkg::NUM_FLAGS-1:0]       o_flags,
    output logic [fbpsw_pkg::WEIGHT_WIDTH-1:0]    o_weight
);

    localparam int VW  = VALUE_WIDTH;
    localparam int WW  = fbpsw_pkg::WEIGHT_WIDTH;
    localparam int FW  = fbpsw_pkg::NUM_FLAGS;
    localparam int DSH = 2 * FRACTION_BITS - fbpsw_pkg::WEIGHT_FRACTION;
    localparam int NW  = 3 * VW;
    localparam int DW  = VW + DSH + WW;
    localparam int CW  = (NW > DW) ? NW : DW;

    // stage 1: qa * qb
    logic            r1_valid;
    logic [2*VW-1:0] r1_pab;
    logic [VW-1:0]   r1_qa;
    logic [VW-1:0]   r1_qb;
    logic [VW-1:0]   r1_qp;
    logic [FW-1:0]   r1_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r1_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_pab   <= (2*VW)'(i_qa) * (2*VW)'(i_qb);
            r1_qa    <= i_qa;
            r1_qb    <= i_qb;
            r1_qp    <= i_qp;
            r1_flags <= i_flags;
        end
    end

    // stage 2: halves of the pair product times qp
    logic            r2_valid;
    logic [2*VW-1:0] r2_plo;
    logic [2*VW-1:0] r2_phi;
    logic [VW-1:0]   r2_qa;
    logic [VW-1:0]   r2_qb;
    logic [VW-1:0]   r2_qp;
    logic [FW-1:0]   r2_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r2_plo   <= (2*VW)'(r1_pab[VW-1:0]) * (2*VW)'(r1_qp);
            r2_phi   <= (2*VW)'(r1_pab[2*VW-1:VW]) * (2*VW)'(r1_qp);
            r2_qa    <= r1_qa;
            r2_qb    <= r1_qb;
            r2_qp    <= r1_qp;
            r2_flags <= r1_flags;
        end
    end

    // stage 3: numerator
    logic          r3_valid;
    logic [NW-1:0] r3_num;
    logic [VW-1:0] r3_qa;
    logic [VW-1:0] r3_qb;
    logic [VW-1:0] r3_qp;
    logic [FW-1:0] r3_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r3_num   <= NW'(r2_plo) + (NW'(r2_phi) << VW);
            r3_qa    <= r2_qa;
            r3_qb    <= r2_qb;
            r3_qp    <= r2_qp;
            r3_flags <= r2_flags;
        end
    end

    // quotient bits, top first; a zero divisor sets every bit
    logic [CW-1:0] den;
    assign den = CW'(i_norm) << DSH;

    logic [NW-1:0] r_wd_rem   [WW];
    logic [WW-1:0] r_wd_quo   [WW];
    logic [VW-1:0] r_wd_qa    [WW];
    logic [VW-1:0] r_wd_qb    [WW];
    logic [VW-1:0] r_wd_qp    [WW];
    logic [FW-1:0] r_wd_flags [WW];
    logic          r_wd_valid [WW];

    for (genvar k = 0; k < WW; k++) begin : g_div
        localparam int BIT = WW - 1 - k;
        logic [NW-1:0] rem_in;
        logic [WW-1:0] quo_in;
        logic [VW-1:0] qa_in;
        logic [VW-1:0] qb_in;
        logic [VW-1:0] qp_in;
        logic [FW-1:0] flags_in;
        logic          valid_in;
        logic [CW-1:0] trial;
        logic [CW-1:0] rem_diff;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in   = r3_num;
            assign quo_in   = '0;
            assign qa_in    = r3_qa;
            assign qb_in    = r3_qb;
            assign qp_in    = r3_qp;
            assign flags_in = r3_flags;
            assign valid_in = r3_valid;
        end else begin : g_next
            assign rem_in   = r_wd_rem[k-1];
            assign quo_in   = r_wd_quo[k-1];
            assign qa_in    = r_wd_qa[k-1];
            assign qb_in    = r_wd_qb[k-1];
            assign qp_in    = r_wd_qp[k-1];
            assign flags_in = r_wd_flags[k-1];
            assign valid_in = r_wd_valid[k-1];
        end

        assign trial    = den << BIT;
        assign take     = (CW'(rem_in) >= trial);
        assign rem_diff = CW'(rem_in) - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_wd_valid[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_wd_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_wd_rem[k]   <= take ? rem_diff[NW-1:0] : rem_in;
                r_wd_quo[k]   <= take ? (quo_in | (WW'(1) << BIT)) : quo_in;
                r_wd_qa[k]    <= qa_in;
                r_wd_qb[k]    <= qb_in;
                r_wd_qp[k]    <= qp_in;
                r_wd_flags[k] <= flags_in;
            end
        end
    end

    assign o_valid  = r_wd_valid[WW-1];
    assign o_qa     = r_wd_qa[WW-1];
    assign o_qb     = r_wd_qb[WW-1];
    assign o_qp     = r_wd_qp[WW-1];
    assign o_flags  = r_wd_flags[WW-1];
    assign o_weight = r_wd_quo[WW-1];

endmodule

// ===== rtl/core/four_body_phase_space_weight.sv =====
// ----------------------------------------------------------------------------
// four_body_phase_space_weight
// Kallen breakup momenta of both pairs and of the pair system, plus weight.
//
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_pair_mass_a, i_pair_mass_b
// result    out        o_valid / i_stall    o_momentum_*, o_weight, o_clamp_flags
// config    in         APB psel/penable     paddr, pwdata, prdata
//
// One transfer per cycle while the result is not stalled. The breakup lanes
// factor, multiply, take the square root one bit a stage and divide one bit a
// stage; the weight then has 3 multiply stages and 32 divide stages.
// Whole pipeline holds while the result is stalled; o_stall follows it.
// Synchronous active-low reset clears the valid bits and loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
module four_body_phase_space_weight #(
    parameter int VALUE_WIDTH   = 24,
    parameter int FRACTION_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [VALUE_WIDTH-1:0]              i_pair_mass_a,
    input  logic [VALUE_WIDTH-1:0]              i_pair_mass_b,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [VALUE_WIDTH-1:0]              o_momentum_a,
    output logic [VALUE_WIDTH-1:0]              o_momentum_b,
    output logic [VALUE_WIDTH-1:0]              o_momentum_pair,
    output logic [fbpsw_pkg::WEIGHT_WIDTH-1:0]  o_weight,
    output logic [fbpsw_pkg::NUM_FLAGS-1:0]     o_clamp_flags,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbpsw_pkg::PADDR_WIDTH-1:0]   paddr,
    input  logic [fbpsw_pkg::PDATA_WIDTH-1:0]   pwdata,
    output logic [fbpsw_pkg::PDATA_WIDTH-1:0]   prdata,
    output logic                                pready
);

    localparam int VW = VALUE_WIDTH;
    localparam int DW = fbpsw_pkg::PDATA_WIDTH;
    localparam logic [VW-1:0] PARENT_RESET = VW'(64'd1000 << FRACTION_BITS);
    localparam logic [VW-1:0] NORM_RESET   = VW'(64'd1 << FRACTION_BITS);

    // configuration registers
    logic [VW-1:0] r_parent_mass;
    logic [VW-1:0] r_mass_one;
    logic [VW-1:0] r_mass_two;
    logic [VW-1:0] r_mass_three;
    logic [VW-1:0] r_mass_four;
    logic [VW-1:0] r_weight_norm;

    fbpsw_pkg::t_reg_idx reg_idx;
    logic                wr_en;

    assign reg_idx = fbpsw_pkg::t_reg_idx'(paddr[fbpsw_pkg::PADDR_WIDTH-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parent_mass <= PARENT_RESET;
            r_mass_one    <= '0;
            r_mass_two    <= '0;
            r_mass_three  <= '0;
            r_mass_four   <= '0;
            r_weight_norm <= NORM_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                fbpsw_pkg::REG_PARENT_MASS: r_parent_mass <= pwdata[VW-1:0];
                fbpsw_pkg::REG_MASS_ONE:    r_mass_one    <= pwdata[VW-1:0];
                fbpsw_pkg::REG_MASS_TWO:    r_mass_two    <= pwdata[VW-1:0];
                fbpsw_pkg::REG_MASS_THREE:  r_mass_three  <= pwdata[VW-1:0];
                fbpsw_pkg::REG_MASS_FOUR:   r_mass_four   <= pwdata[VW-1:0];
                fbpsw_pkg::REG_WEIGHT_NORM: r_weight_norm <= pwdata[VW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fbpsw_pkg::REG_PARENT_MASS: prdata = DW'(r_parent_mass);
            fbpsw_pkg::REG_MASS_ONE:    prdata = DW'(r_mass_one);
            fbpsw_pkg::REG_MASS_TWO:    prdata = DW'(r_mass_two);
            fbpsw_pkg::REG_MASS_THREE:  prdata = DW'(r_mass_three);
            fbpsw_pkg::REG_MASS_FOUR:   prdata = DW'(r_mass_four);
            fbpsw_pkg::REG_WEIGHT_NORM: prdata = DW'(r_weight_norm);
            default:                    prdata = '0;
        endcase
    end

    // pipeline control
    fbpsw_pkg::t_pipe_ctl in_ctl;
    fbpsw_pkg::t_pipe_ctl mid_ctl;
    logic                 pipe_en;

    assign pipe_en      = !(o_valid && i_stall);
    assign o_stall      = !pipe_en;
    assign in_ctl.en    = pipe_en;
    assign in_ctl.valid = i_valid;

    logic          valid_a;
    logic          valid_b;
    logic          valid_p;
    logic [VW-1:0] q_a;
    logic [VW-1:0] q_b;
    logic [VW-1:0] q_p;
    logic          neg_a;
    logic          neg_b;
    logic          neg_p;

    fbpsw_breakup #(.VALUE_WIDTH(VW)) u_lane_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (in_ctl),
        .i_mass     (i_pair_mass_a),
        .i_part_x   (r_mass_one),
        .i_part_y   (r_mass_two),
        .o_valid    (valid_a),
        .o_momentum (q_a),
        .o_clamp    (neg_a)
    );

    fbpsw_breakup #(.VALUE_WIDTH(VW)) u_lane_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (in_ctl),
        .i_mass     (i_pair_mass_b),
        .i_part_x   (r_mass_three),
        .i_part_y   (r_mass_four),
        .o_valid    (valid_b),
        .o_momentum (q_b),
        .o_clamp    (neg_b)
    );

    fbpsw_breakup #(.VALUE_WIDTH(VW)) u_lane_p (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (in_ctl),
        .i_mass     (r_parent_mass),
        .i_part_x   (i_pair_mass_a),
        .i_part_y   (i_pair_mass_b),
        .o_valid    (valid_p),
        .o_momentum (q_p),
        .o_clamp    (neg_p)
    );

    assign mid_ctl.en    = pipe_en;
    assign mid_ctl.valid = valid_a && valid_b && valid_p;

    fbpsw_weight #(
        .VALUE_WIDTH   (VW),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_weight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mid_ctl),
        .i_norm   (r_weight_norm),
        .i_qa     (q_a),
        .i_qb     (q_b),
        .i_qp     (q_p),
        .i_flags  ({neg_p, neg_b, neg_a}),
        .o_valid  (o_valid),
        .o_qa     (o_momentum_a),
        .o_qb     (o_momentum_b),
        .o_qp     (o_momentum_pair),
        .o_flags  (o_clamp_flags),
        .o_weight (o_weight)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for four_body_phase_space_weight. Mass pairs are
// streamed in under random idling on both sides, in phases with different
// parent, daughter and norm settings written over APB while the pipe is empty.
// Each result is checked field by field against an exact-integer prediction
// of the three breakup momenta, the clamp flags and the saturating weight.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VW   = 24;
    localparam int FB   = 12;
    localparam int WW   = fbpsw_pkg::WEIGHT_WIDTH;
    localparam int NF   = fbpsw_pkg::NUM_FLAGS;
    localparam int AW   = fbpsw_pkg::PADDR_WIDTH;
    localparam int PW   = fbpsw_pkg::PDATA_WIDTH;
    localparam int SHFT = 2 * FB - fbpsw_pkg::WEIGHT_FRACTION;
    localparam logic [VW-1:0] VMAX = '1;

    typedef logic [191:0] t_wide;

    typedef struct packed {
        logic [VW-1:0] ma;
        logic [VW-1:0] mb;
    } t_mass_pair;

    typedef struct packed {
        logic [VW-1:0] qa;
        logic [VW-1:0] qb;
        logic [VW-1:0] qp;
        logic [WW-1:0] w;
        logic [NF-1:0] flags;
    } t_phase_space;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [VW-1:0]          i_pair_mass_a = '0;
    logic [VW-1:0]          i_pair_mass_b = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [VW-1:0]          o_momentum_a, o_momentum_b, o_momentum_pair;
    logic [WW-1:0]          o_weight;
    logic [NF-1:0]          o_clamp_flags;
    logic                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0]          paddr = '0;
    logic [PW-1:0]          pwdata = '0;
    logic [PW-1:0]          prdata;
    logic                   pready;

    four_body_phase_space_weight #(.VALUE_WIDTH(VW), .FRACTION_BITS(FB)) dut (.*);

    always #5 i_clk = ~i_clk;

    logic [VW-1:0] cfg [6];
    t_mass_pair    pending_pairs[$];
    t_phase_space  expected_results[$];
    t_mass_pair    cur_pair;
    int            send_gap = 0, stall_gap = 0;
    bit            quiet = 0;
    int            errors = 0, results_seen = 0, pairs_sent = 0, cycles = 0;
    int            clamp_seen [NF];
    int            weight_sat = 0;

    function automatic logic [VW-1:0] breakup(input logic [VW-1:0] m, x, y,
                                              output logic neg);
        logic [63:0]   s, d, f1, f2, f3, f4, c;
        logic [VW-1:0] q;
        t_wide         lam, t;
        s   = 64'(x) + 64'(y);
        d   = (x > y) ? 64'(x - y) : 64'(y - x);
        neg = 1'b0;
        q   = '0;
        if (d < 64'(m) && 64'(m) < s) begin
            neg = 1'b1;
            return '0;
        end
        f1  = (64'(m) > s) ? 64'(m) - s : s - 64'(m);
        f2  = 64'(m) + s;
        f3  = (64'(m) > d) ? 64'(m) - d : d - 64'(m);
        f4  = 64'(m) + d;
        lam = t_wide'(f1) * t_wide'(f2) * t_wide'(f3) * t_wide'(f4);
        for (int b = VW - 1; b >= 0; b--) begin
            c = 64'(q) | (64'd1 << b);
            t = t_wide'(2 * 64'(m)) * t_wide'(c);
            t = t * t;
            if (t <= lam) q = c[VW-1:0];
        end
        return q;
    endfunction

    function automatic t_phase_space predict_weight(t_mass_pair p);
        t_phase_space r;
        logic         na, nb, np;
        t_wide        num, den;
        logic [63:0]  c;
        r.qa  = breakup(p.ma, cfg[fbpsw_pkg::REG_MASS_ONE], cfg[fbpsw_pkg::REG_MASS_TWO], na);
        r.qb  = breakup(p.mb, cfg[fbpsw_pkg::REG_MASS_THREE], cfg[fbpsw_pkg::REG_MASS_FOUR],
                        nb);
        r.qp  = breakup(cfg[fbpsw_pkg::REG_PARENT_MASS], p.ma, p.mb, np);
        r.flags = {np, nb, na};
        num = t_wide'(r.qa) * t_wide'(r.qb) * t_wide'(r.qp);
        den = t_wide'(cfg[fbpsw_pkg::REG_WEIGHT_NORM]) << SHFT;
        r.w = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            c = 64'(r.w) | (64'd1 << b);
            if (t_wide'(c) * den <= num) r.w = c[WW-1:0];
        end
        return r;
    endfunction

    // sender
    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nv = i_valid;
            if (i_valid && !o_stall) begin
                expected_results.push_back(predict_weight(cur_pair));
                pairs_sent++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_pairs.size() > 0) begin
                    cur_pair = pending_pairs.pop_front();
                    i_pair_mass_a <= cur_pair.ma;
                    i_pair_mass_b <= cur_pair.mb;
                    nv = 1'b1;
                    if (!quiet && $urandom_range(0, 15) == 0)
                        send_gap = $urandom_range(1, 12);
                end
            end
            i_valid <= nv;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        t_phase_space exp_r;
        if (i_rst_n) begin
            cycles++;
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result transfer");
                end else begin
                    exp_r = expected_results.pop_front();
                    for (int k = 0; k < NF; k++)
                        if (o_clamp_flags[k]) clamp_seen[k]++;
                    if (o_weight == '1) weight_sat++;
                    if (o_momentum_a !== exp_r.qa || o_momentum_b !== exp_r.qb ||
                        o_momentum_pair !== exp_r.qp || o_weight !== exp_r.w ||
                        o_clamp_flags !== exp_r.flags) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp qa=%h qb=%h qp=%h w=%h f=%b got %h %h %h %h %b",
                                exp_r.qa, exp_r.qb, exp_r.qp, exp_r.w, exp_r.flags,
                                o_momentum_a, o_momentum_b, o_momentum_pair, o_weight,
                                o_clamp_flags);
                    end
                end
            end
            if (stall_gap > 0) begin
                stall_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 15) == 0)
                    stall_gap = $urandom_range(1, 12);
            end
            if (cycles > 2000000) begin
                $display("timeout");
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic reg_write(fbpsw_pkg::t_reg_idx idx, logic [VW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'({idx, 2'b00});
        pwdata  <= PW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg[idx] = val;
    endtask

    task automatic set_masses(logic [VW-1:0] pm, m1, m2, m3, m4, wn);
        reg_write(fbpsw_pkg::REG_PARENT_MASS, pm);
        reg_write(fbpsw_pkg::REG_MASS_ONE, m1);
        reg_write(fbpsw_pkg::REG_MASS_TWO, m2);
        reg_write(fbpsw_pkg::REG_MASS_THREE, m3);
        reg_write(fbpsw_pkg::REG_MASS_FOUR, m4);
        reg_write(fbpsw_pkg::REG_WEIGHT_NORM, wn);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_pairs.size() > 0 || i_valid || expected_results.size() > 0);
        repeat (130) @(posedge i_clk);
    endtask

    function automatic logic [VW-1:0] sat(logic [31:0] v);
        return (v > 32'(VMAX)) ? VMAX : v[VW-1:0];
    endfunction

    task automatic push_pair(logic [VW-1:0] a, b);
        pending_pairs.push_back('{ma: a, mb: b});
    endtask

    task automatic random_pairs(int n);
        logic [31:0] lo_a, lo_b, hi;
        for (int i = 0; i < n; i++) begin
            lo_a = 32'(cfg[fbpsw_pkg::REG_MASS_ONE]) + 32'(cfg[fbpsw_pkg::REG_MASS_TWO]);
            lo_b = 32'(cfg[fbpsw_pkg::REG_MASS_THREE]) + 32'(cfg[fbpsw_pkg::REG_MASS_FOUR]);
            hi   = 32'(cfg[fbpsw_pkg::REG_PARENT_MASS]);
            case ($urandom_range(0, 9))
                0, 1, 2: push_pair(VW'($urandom), VW'($urandom));
                3: push_pair(sat(lo_a), sat(lo_b));
                4: push_pair(sat(lo_a + $urandom_range(0, 8)), VW'($urandom_range(0, 16)));
                default: begin
                    // physical region: ma + mb at most the parent mass
                    logic [31:0] a, b;
                    a = (hi > lo_a + lo_b) ? lo_a + $urandom_range(0, hi - lo_a - lo_b) : lo_a;
                    b = (hi > a + lo_b) ? lo_b + $urandom_range(0, hi - a - lo_b) : lo_b;
                    push_pair(sat(a), sat(b));
                end
            endcase
        end
    endtask

    initial begin
        logic [VW-1:0] m1, m2, m3, m4;
        cfg[fbpsw_pkg::REG_PARENT_MASS] = 24'd4096000;
        cfg[fbpsw_pkg::REG_MASS_ONE]    = '0;
        cfg[fbpsw_pkg::REG_MASS_TWO]    = '0;
        cfg[fbpsw_pkg::REG_MASS_THREE]  = '0;
        cfg[fbpsw_pkg::REG_MASS_FOUR]   = '0;
        cfg[fbpsw_pkg::REG_WEIGHT_NORM] = 24'd4096;
        for (int k = 0; k < NF; k++) clamp_seen[k] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero masses, extremes of the pair fields
        push_pair('0, '0);
        push_pair(VMAX, VMAX);
        push_pair(VMAX, '0);
        push_pair(24'd4096, 24'd8192);
        push_pair(24'd2048000, 24'd2048000);
        push_pair(24'd2048000, 24'd2048001);
        push_pair(24'h555555, 24'hAAAAAA);
        drain();

        // thresholds: zero radicand, clamp, mass below |x - y|, zero mass
        m1 = 24'd409600; m2 = 24'd204800; m3 = 24'd122880; m4 = 24'd40960;
        set_masses(24'd4096000, m1, m2, m3, m4, 24'd1);
        push_pair(m1 + m2, m3 + m4);
        push_pair(m1 - m2, m3 - m4);
        push_pair(m1, m3);
        push_pair(m1 - m2 - 1, m3 - m4 - 1);
        push_pair('0, '0);
        push_pair(24'd1, 24'd1);
        push_pair(24'd1024000, 24'd1024000);
        push_pair(24'd4096000 - m3 - m4, m3 + m4);
        push_pair(24'd3000000, 24'd2000000);
        push_pair(VMAX, VMAX);
        drain();

        set_masses(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
        push_pair(VMAX, VMAX);
        push_pair('0, '0);
        push_pair(24'd1, VMAX);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            m1 = VW'($urandom_range(0, 1 << (10 + ph * 2)));
            m2 = VW'($urandom_range(0, 1 << (10 + ph * 2)));
            m3 = VW'($urandom_range(0, 1 << (10 + ph * 2)));
            m4 = VW'($urandom_range(0, 1 << (10 + ph * 2)));
            set_masses(VW'($urandom_range(1 << 20, VMAX)), m1, m2, m3, m4,
                       (ph == 0) ? 24'd1 : VW'($urandom_range(1, VMAX)));
            if (ph == 7) quiet = 1;
            random_pairs(120);
            drain();
        end

        $display("tb_top: %0d mass pairs sent, %0d results; clamps a/b/pair %0d/%0d/%0d",
                 pairs_sent, results_seen, clamp_seen[0], clamp_seen[1], clamp_seen[2]);
        $display("tb_top: %0d saturated weights, 11 register settings", weight_sat);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/fbpsw_pkg.sv
rtl/core/fbpsw_breakup.sv
rtl/core/fbpsw_weight.sv
rtl/core/four_body_phase_space_weight.sv
tb/sv/tb_top.sv
